>>> rtl/satq_pkg.sv
`default_nettype none

package satq_pkg;

   // Operation codes carried in the request.
   localparam logic [2:0] FUNC_CREATE = 3'd0;
   localparam logic [2:0] FUNC_DELETE = 3'd1;
   localparam logic [2:0] FUNC_EDIT   = 3'd2;
   localparam logic [2:0] FUNC_FIRE   = 3'd3;
   localparam logic [2:0] FUNC_REVAL  = 3'd4;
   localparam logic [2:0] FUNC_READ   = 3'd5;

   // Status codes returned with each result.
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_PAST    = 3'd1;
   localparam logic [2:0] ST_TOO_FAR = 3'd2;
   localparam logic [2:0] ST_DUP     = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;
   localparam logic [2:0] ST_BAD_IDX = 3'd5;
   localparam logic [2:0] ST_EMPTY   = 3'd6;

   // Control register indexes.
   localparam logic [1:0] CSR_BUFFER_SEC    = 2'd0;
   localparam logic [1:0] CSR_MAX_AHEAD_SEC = 2'd1;
   localparam logic [1:0] CSR_RETRY_SEC     = 2'd2;

   // Reset values of the control registers.
   localparam logic [11:0] BUFFER_SEC_RST    = 12'd5;
   localparam logic [31:0] MAX_AHEAD_SEC_RST = 32'd31536000;
   localparam logic [11:0] RETRY_SEC_RST     = 12'd5;

   // Microseconds per second.
   localparam logic [19:0] US_PER_SEC = 20'd1000000;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] now_sec;
      logic [31:0] alarm_epoch;
      logic [5:0]  slot;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [2:0]  status;
      logic [6:0]  count;
      logic [31:0] value_epoch;
      logic        rearmed;
      logic        timer_armed;
      logic [51:0] timeout_us;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/satq_ram.sv
`default_nettype none

module satq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/sorted_alarm_timer_queue_core.sv
`default_nettype none

// Sorted alarm queue with a one-shot timer model.
// A request is transferred at a rising edge with start high and busy low. It carries
// an operation code, the current epoch second, an alarm epoch and a list slot.
// Exactly one result follows per request: rsp_valid is high for one cycle with
// rsp_data, and the receiver has to take it in that cycle; it cannot stall.
// Control registers are written through the csr_ channel, which is always ready;
// writes belong in idle periods.
// The alarms sit ascending in a single-port-read memory of MAX_ALARMS entries.
// Scans and shifts walk that memory one entry per cycle through its one read
// port, so the time a request takes grows with the count and with the number
// of entries shifted, and most for an edit that has to restore its old alarm.
// busy stays high from the transfer until the result strobe; one request is
// in work at a time, and the next one can be taken in the strobe cycle.
// Reset empties the list, stops the timer and restores the register defaults;
// the memory itself is not cleared, since only entries below the count are read.

module sorted_alarm_timer_queue_core #(
   parameter int MAX_ALARMS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire satq_pkg::req_type req_data,
   output logic                   rsp_valid,
   output satq_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_data
);

   localparam int AW = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
   localparam int CW = $clog2(MAX_ALARMS + 1);
   localparam logic [CW-1:0] NC = CW'(MAX_ALARMS);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DEC     = 4'd1;
   localparam logic [3:0] S_GET     = 4'd2;
   localparam logic [3:0] S_RM      = 4'd3;
   localparam logic [3:0] S_MOVE    = 4'd4;
   localparam logic [3:0] S_RM_END  = 4'd5;
   localparam logic [3:0] S_HEAD_RD = 4'd6;
   localparam logic [3:0] S_HEAD    = 4'd7;
   localparam logic [3:0] S_CHK     = 4'd8;
   localparam logic [3:0] S_SCAN    = 4'd9;
   localparam logic [3:0] S_SCAN_END = 4'd10;
   localparam logic [3:0] S_INS     = 4'd11;
   localparam logic [3:0] S_RV_END  = 4'd12;
   localparam logic [3:0] S_RESP    = 4'd13;
   localparam logic [3:0] S_CONT    = 4'd14;

   logic [3:0]    state_ff, state_in;
   logic [2:0]    func_ff, func_in;
   logic [31:0]   now_ff, now_in;
   logic [31:0]   epoch_ff, epoch_in;
   logic [5:0]    slot_ff, slot_in;
   logic [31:0]   cur_e_ff, cur_e_in;
   logic [31:0]   old_ff, old_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          cont_cre_ff, cont_cre_in;
   logic          edit_stage_ff, edit_stage_in;
   logic [CW-1:0] k_ff, k_in;
   logic          vld_ff, vld_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          dup_ff, dup_in;
   logic [AW-1:0] src_ff, src_in;
   logic [AW-1:0] dst_ff, dst_in;
   logic [CW-1:0] len_ff, len_in;
   logic          step_dn_ff, step_dn_in;
   logic [3:0]    mv_ret_ff, mv_ret_in;
   logic [CW-1:0] count_ff, count_in;
   logic          armed_ff, armed_in;
   logic [11:0]   buf_ff, buf_in;
   logic [31:0]   ahead_ff, ahead_in;
   logic [11:0]   retry_ff, retry_in;
   logic          ok_ff, ok_in;
   logic [2:0]    status_ff, status_in;
   logic [31:0]   value_ff, value_in;
   logic          rearm_ff, rearm_in;
   logic [31:0]   mulop_ff, mulop_in;
   logic          rsp_valid_ff, rsp_valid_in;
   satq_pkg::rsp_type rsp_ff, rsp_in;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;

   logic [32:0]   limit;
   logic [31:0]   head_val;
   logic [31:0]   arm_op;
   logic [31:0]   diff;
   logic          full;
   logic          bad_slot;
   logic [CW-1:0] ins_top;
   logic          cre_done;
   logic [2:0]    cre_code;

   satq_ram #(
      .WIDTH(32),
      .DEPTH(MAX_ALARMS)
   ) u_list (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Guard limit and timer delay; sums with the buffer are kept at 33 bits.
   assign limit    = {1'b0, now_ff} + 33'(buf_ff);
   assign head_val = (state_ff == S_HEAD) ? rd_data : cur_e_ff;
   assign arm_op   = ({1'b0, head_val} > limit) ? (head_val - now_ff) : 32'(retry_ff);
   assign diff     = cur_e_ff - now_ff;
   assign full     = (count_ff == NC);
   assign bad_slot = ({1'b0, slot_ff} >= 7'(count_ff));
   assign ins_top  = full ? (NC - CW'(1)) : count_ff;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Control register writes.
   always_comb begin
      buf_in   = buf_ff;
      ahead_in = ahead_ff;
      retry_in = retry_ff;
      if (csr_valid) begin
         unique case (csr_index)
            satq_pkg::CSR_BUFFER_SEC:    buf_in   = csr_data[11:0];
            satq_pkg::CSR_MAX_AHEAD_SEC: ahead_in = csr_data;
            satq_pkg::CSR_RETRY_SEC:     retry_in = csr_data[11:0];
            default: ;
         endcase
      end
   end

   // Operation sequencer around the alarm memory.
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      now_in        = now_ff;
      epoch_in      = epoch_ff;
      slot_in       = slot_ff;
      cur_e_in      = cur_e_ff;
      old_in        = old_ff;
      idx_in        = idx_ff;
      cont_cre_in   = cont_cre_ff;
      edit_stage_in = edit_stage_ff;
      k_in          = k_ff;
      vld_in        = vld_ff;
      cnt_in        = cnt_ff;
      dup_in        = dup_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      len_in        = len_ff;
      step_dn_in    = step_dn_ff;
      mv_ret_in     = mv_ret_ff;
      count_in      = count_ff;
      armed_in      = armed_ff;
      ok_in         = ok_ff;
      status_in     = status_ff;
      value_in      = value_ff;
      rearm_in      = rearm_ff;
      mulop_in      = mulop_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = rd_data;
      cre_done      = 1'b0;
      cre_code      = satq_pkg::ST_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in       = req_data.func;
               now_in        = req_data.now_sec;
               epoch_in      = req_data.alarm_epoch;
               slot_in       = req_data.slot;
               ok_in         = 1'b0;
               status_in     = satq_pkg::ST_OK;
               value_in      = '0;
               rearm_in      = 1'b0;
               mulop_in      = '0;
               edit_stage_in = 1'b0;
               cont_cre_in   = 1'b0;
               state_in      = S_DEC;
            end
         end

         S_DEC: begin
            unique case (func_ff)
               satq_pkg::FUNC_CREATE: begin
                  cur_e_in = epoch_ff;
                  state_in = S_CHK;
               end
               satq_pkg::FUNC_DELETE: begin
                  if (bad_slot) begin
                     status_in = satq_pkg::ST_BAD_IDX;
                     state_in  = S_RESP;
                  end else begin
                     ok_in       = 1'b1;
                     idx_in      = slot_ff[AW-1:0];
                     cont_cre_in = 1'b0;
                     state_in    = S_RM;
                  end
               end
               satq_pkg::FUNC_EDIT, satq_pkg::FUNC_READ: begin
                  if (bad_slot) begin
                     status_in = satq_pkg::ST_BAD_IDX;
                     state_in  = S_RESP;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = slot_ff[AW-1:0];
                     state_in = S_GET;
                  end
               end
               satq_pkg::FUNC_FIRE: begin
                  // The timer has expired, so it is no longer running.
                  armed_in = 1'b0;
                  if (count_ff == '0) begin
                     status_in = satq_pkg::ST_EMPTY;
                     state_in  = S_RESP;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = S_GET;
                  end
               end
               satq_pkg::FUNC_REVAL: begin
                  ok_in       = 1'b1;
                  cont_cre_in = 1'b0;
                  k_in        = '0;
                  vld_in      = 1'b0;
                  cnt_in      = '0;
                  dup_in      = 1'b0;
                  state_in    = S_SCAN;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         S_GET: begin
            case (func_ff)
               satq_pkg::FUNC_READ: begin
                  value_in = rd_data;
                  ok_in    = 1'b1;
                  state_in = S_RESP;
               end
               satq_pkg::FUNC_FIRE: begin
                  value_in    = rd_data;
                  ok_in       = 1'b1;
                  idx_in      = '0;
                  cont_cre_in = 1'b0;
                  state_in    = S_RM;
               end
               default: begin
                  old_in      = rd_data;
                  idx_in      = slot_ff[AW-1:0];
                  cont_cre_in = 1'b1;
                  state_in    = S_RM;
               end
            endcase
         end

         // Close the gap left by the removed entry.
         S_RM: begin
            src_in     = idx_ff + AW'(1);
            dst_in     = idx_ff;
            len_in     = count_ff - CW'(1) - CW'(idx_ff);
            step_dn_in = 1'b0;
            k_in       = '0;
            vld_in     = 1'b0;
            mv_ret_in  = S_RM_END;
            state_in   = S_MOVE;
         end

         // Pipelined copy: one read issued and one write retired per cycle.
         S_MOVE: begin
            if (k_ff != len_ff) begin
               rd_en   = 1'b1;
               rd_addr = src_ff;
               src_in  = step_dn_ff ? (src_ff - AW'(1)) : (src_ff + AW'(1));
               k_in    = k_ff + CW'(1);
               vld_in  = 1'b1;
            end else begin
               vld_in = 1'b0;
            end
            if (vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = dst_ff;
               wr_data = rd_data;
               dst_in  = step_dn_ff ? (dst_ff - AW'(1)) : (dst_ff + AW'(1));
            end
            if ((k_ff == len_ff) && !vld_ff) begin
               state_in = mv_ret_ff;
            end
         end

         S_RM_END: begin
            count_in = count_ff - CW'(1);
            state_in = S_CONT;
            if (idx_ff == '0) begin
               if (count_ff > CW'(1)) begin
                  state_in = S_HEAD_RD;
               end else begin
                  armed_in = 1'b0;
               end
            end
         end

         S_HEAD_RD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_HEAD;
         end

         // Restart the timer for the new head.
         S_HEAD: begin
            armed_in = 1'b1;
            rearm_in = 1'b1;
            mulop_in = arm_op;
            state_in = S_CONT;
         end

         S_CONT: begin
            if (cont_cre_ff) begin
               cur_e_in = epoch_ff;
               state_in = S_CHK;
            end else begin
               state_in = S_RESP;
            end
         end

         // Range checks of a new alarm.
         S_CHK: begin
            if ((cur_e_ff <= now_ff) || (diff <= 32'(buf_ff))) begin
               cre_done = 1'b1;
               cre_code = satq_pkg::ST_PAST;
            end else if (diff > ahead_ff) begin
               cre_done = 1'b1;
               cre_code = satq_pkg::ST_TOO_FAR;
            end else begin
               k_in     = '0;
               vld_in   = 1'b0;
               cnt_in   = '0;
               dup_in   = 1'b0;
               state_in = S_SCAN;
            end
         end

         // Count entries below the new alarm, or entries inside the guard window; flag an equal entry.
         S_SCAN: begin
            if (k_ff != count_ff) begin
               rd_en   = 1'b1;
               rd_addr = k_ff[AW-1:0];
               k_in    = k_ff + CW'(1);
               vld_in  = 1'b1;
            end else begin
               vld_in = 1'b0;
            end
            if (vld_ff) begin
               if (func_ff == satq_pkg::FUNC_REVAL) begin
                  if ({1'b0, rd_data} <= limit) begin
                     cnt_in = cnt_ff + CW'(1);
                  end
               end else begin
                  if (rd_data < cur_e_ff) begin
                     cnt_in = cnt_ff + CW'(1);
                  end
                  if (rd_data == cur_e_ff) begin
                     dup_in = 1'b1;
                  end
               end
            end
            if ((k_ff == count_ff) && !vld_ff) begin
               state_in = S_SCAN_END;
            end
         end

         S_SCAN_END: begin
            if (func_ff == satq_pkg::FUNC_REVAL) begin
               if (cnt_ff == '0) begin
                  state_in = S_RV_END;
               end else begin
                  src_in     = cnt_ff[AW-1:0];
                  dst_in     = '0;
                  len_in     = count_ff - cnt_ff;
                  step_dn_in = 1'b0;
                  k_in       = '0;
                  vld_in     = 1'b0;
                  mv_ret_in  = S_RV_END;
                  state_in   = S_MOVE;
               end
            end else if (dup_ff) begin
               cre_done = 1'b1;
               cre_code = satq_pkg::ST_DUP;
            end else if (full && (cnt_ff == NC)) begin
               cre_done = 1'b1;
               cre_code = satq_pkg::ST_FULL;
            end else begin
               // Open a hole at the insert position; a full list drops its last entry.
               src_in     = AW'(ins_top - CW'(1));
               dst_in     = AW'(ins_top);
               len_in     = ins_top - cnt_ff;
               step_dn_in = 1'b1;
               k_in       = '0;
               vld_in     = 1'b0;
               mv_ret_in  = S_INS;
               state_in   = S_MOVE;
            end
         end

         S_INS: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[AW-1:0];
            wr_data = cur_e_ff;
            if (!full) begin
               count_in = count_ff + CW'(1);
            end
            if (cnt_ff == '0) begin
               armed_in = 1'b1;
               rearm_in = 1'b1;
               mulop_in = arm_op;
            end
            cre_done = 1'b1;
            cre_code = satq_pkg::ST_OK;
         end

         S_RV_END: begin
            count_in = count_ff - cnt_ff;
            if (count_ff != cnt_ff) begin
               state_in = S_HEAD_RD;
            end else begin
               armed_in = 1'b0;
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            rsp_valid_in       = 1'b1;
            rsp_in.ok          = ok_ff;
            rsp_in.status      = status_ff;
            rsp_in.count       = 7'(count_ff);
            rsp_in.value_epoch = value_ff;
            rsp_in.rearmed     = rearm_ff;
            rsp_in.timer_armed = armed_ff;
            rsp_in.timeout_us  = 52'(mulop_ff) * 52'(satq_pkg::US_PER_SEC);
            state_in           = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Outcome of a create; a failed edit puts the old alarm back.
      if (cre_done) begin
         if (edit_stage_ff) begin
            state_in = S_RESP;
         end else if ((func_ff == satq_pkg::FUNC_EDIT) && (cre_code != satq_pkg::ST_OK)) begin
            status_in     = cre_code;
            ok_in         = 1'b0;
            cur_e_in      = old_ff;
            edit_stage_in = 1'b1;
            state_in      = S_CHK;
         end else begin
            status_in = cre_code;
            ok_in     = (cre_code == satq_pkg::ST_OK);
            state_in  = S_RESP;
         end
      end
   end

   // Control state with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         armed_ff     <= 1'b0;
         buf_ff       <= satq_pkg::BUFFER_SEC_RST;
         ahead_ff     <= satq_pkg::MAX_AHEAD_SEC_RST;
         retry_ff     <= satq_pkg::RETRY_SEC_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         armed_ff     <= armed_in;
         buf_ff       <= buf_in;
         ahead_ff     <= ahead_in;
         retry_ff     <= retry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      now_ff        <= now_in;
      epoch_ff      <= epoch_in;
      slot_ff       <= slot_in;
      cur_e_ff      <= cur_e_in;
      old_ff        <= old_in;
      idx_ff        <= idx_in;
      cont_cre_ff   <= cont_cre_in;
      edit_stage_ff <= edit_stage_in;
      k_ff          <= k_in;
      vld_ff        <= vld_in;
      cnt_ff        <= cnt_in;
      dup_ff        <= dup_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      len_ff        <= len_in;
      step_dn_ff    <= step_dn_in;
      mv_ret_ff     <= mv_ret_in;
      ok_ff         <= ok_in;
      status_ff     <= status_in;
      value_ff      <= value_in;
      rearm_ff      <= rearm_in;
      mulop_ff      <= mulop_in;
      rsp_ff        <= rsp_in;
   end

endmodule

`default_nettype wire
